### src/dbp_pkg.sv
// dbp_pkg: shared constants and payload types for the duplex byte pipe
// used by the front, queue, back and top modules; no dependencies of its own
`default_nettype none

package dbp_pkg;

  // ring size per direction; a power of two so ring positions wrap naturally
  localparam int RING_BYTES = 16 * 1024;
  localparam int PTR_W      = $clog2(RING_BYTES);
  localparam int CNT_W      = $clog2(RING_BYTES + 1);
  localparam int ADDR_W     = PTR_W + 1;
  localparam int STORE_BYTES = 2 * RING_BYTES;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0] RING_FULL = CNT_W'(RING_BYTES);

  // operation codes
  localparam logic [2:0] OP_OPEN  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_READ  = 3'd2;
  localparam logic [2:0] OP_PEEK  = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_WOULD_BLOCK   = 3'd1;
  localparam logic [2:0] ST_BROKEN_PIPE   = 3'd2;
  localparam logic [2:0] ST_END_OF_STREAM = 3'd3;
  localparam logic [2:0] ST_NOT_CONNECTED = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic        side;
    logic [7:0]  write_data;
    logic [13:0] peek_offset;
    logic        end_of_transfer;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic        readable;
    logic        writable;
    logic [14:0] bytes_waiting;
    logic        transfer_done;
  } rsp_t;

  // work handed from the front part to the back part through the queue
  typedef struct packed {
    logic              do_write;
    logic              do_read;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    rsp_t              rsp;
  } job_t;

endpackage

`default_nettype wire

### src/dbp_ram.sv
// dbp_ram: generic simple dual-port RAM, one write and one registered read port
// stand-alone; width and depth come from its parameters
`default_nettype none

module dbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/dbp_front.sv
// dbp_front: takes operations, keeps ring positions, fill counts and end state,
// and turns each operation into a job for the back part; uses dbp_pkg
`default_nettype none

module dbp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dbp_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output      logic          cmd_stall,
  output      dbp_pkg::job_t job,
  output      logic          job_push,
  input  wire logic          job_full
);
  import dbp_pkg::*;

  logic [PTR_W-1:0] wp [2];
  logic [PTR_W-1:0] rp [2];
  logic [CNT_W-1:0] fill [2];
  logic [1:0]       closed;

  logic [PTR_W-1:0] wp_next [2];
  logic [PTR_W-1:0] rp_next [2];
  logic [CNT_W-1:0] fill_next [2];
  logic [1:0]       closed_next;

  logic       acc;
  logic       d;
  logic       r;
  logic [2:0] status;

  assign cmd_stall = job_full;
  assign acc       = cmd_valid && !job_full;
  assign job_push  = acc;
  assign d         = cmd.side;
  assign r         = ~cmd.side;

  always_comb begin
    wp_next       = wp;
    rp_next       = rp;
    fill_next     = fill;
    closed_next   = closed;
    status        = ST_OK;
    job.do_write  = 1'b0;
    job.do_read   = 1'b0;
    job.addr      = '0;
    job.wdata     = cmd.write_data;

    priority if (cmd.operation == OP_OPEN) begin
      wp_next     = '{default: '0};
      rp_next     = '{default: '0};
      fill_next   = '{default: '0};
      closed_next = 2'b00;
    end else if (cmd.operation <= OP_CLOSE && closed[d]) begin
      status = ST_NOT_CONNECTED;
    end else begin
      unique case (cmd.operation)
        OP_WRITE: begin
          priority if (closed[r]) begin
            status = ST_BROKEN_PIPE;
          end else if (fill[d] >= RING_FULL) begin
            status = ST_WOULD_BLOCK;
          end else begin
            job.do_write = 1'b1;
            job.addr     = {d, wp[d]};
            wp_next[d]   = wp[d] + 1'b1;
            fill_next[d] = fill[d] + 1'b1;
          end
        end
        OP_READ: begin
          if (fill[r] == '0) begin
            status = closed[r] ? ST_END_OF_STREAM : ST_WOULD_BLOCK;
          end else begin
            job.do_read  = 1'b1;
            job.addr     = {r, rp[r]};
            rp_next[r]   = rp[r] + 1'b1;
            fill_next[r] = fill[r] - 1'b1;
          end
        end
        OP_PEEK: begin
          if (32'(cmd.peek_offset) >= 32'(fill[r])) begin
            status = closed[r] ? ST_END_OF_STREAM : ST_WOULD_BLOCK;
          end else begin
            job.do_read = 1'b1;
            job.addr    = {r, rp[r] + PTR_W'(cmd.peek_offset)};
          end
        end
        OP_CLOSE: begin
          closed_next[d] = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // flags and count reflect the state after this operation
    job.rsp.status        = status;
    job.rsp.read_data     = 8'd0;
    job.rsp.transfer_done = cmd.end_of_transfer;
    if (closed_next[d]) begin
      job.rsp.readable      = 1'b0;
      job.rsp.writable      = 1'b0;
      job.rsp.bytes_waiting = 15'd0;
    end else begin
      job.rsp.readable      = (fill_next[r] != '0) || closed_next[r];
      job.rsp.writable      = closed_next[r] || (fill_next[d] < RING_FULL);
      job.rsp.bytes_waiting = 15'(fill_next[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '{default: '0};
      rp     <= '{default: '0};
      fill   <= '{default: '0};
      closed <= 2'b11;
    end else if (acc) begin
      wp     <= wp_next;
      rp     <= rp_next;
      fill   <= fill_next;
      closed <= closed_next;
    end
  end

  a_open_revives: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd.operation == OP_OPEN) |=> (closed == 2'b00 && fill[0] == '0 && fill[1] == '0))
    else $error("open did not clear both ends");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= RING_FULL) && (fill[1] <= RING_FULL))
    else $error("fill count beyond ring size");

endmodule

`default_nettype wire

### src/dbp_queue.sv
// dbp_queue: short job queue between the front and back parts
// register based; uses dbp_pkg for the job type and depth
`default_nettype none

module dbp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dbp_pkg::job_t push_job,
  input  wire logic          push,
  output      logic          full,
  output      dbp_pkg::job_t head,
  output      logic          empty,
  input  wire logic          pop
);
  import dbp_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  job_t              slots [QUEUE_DEPTH];
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_QW-1:0] count;

  assign full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= (rd_idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### src/dbp_back.sv
// dbp_back: pops jobs, performs ring writes and reads, holds the result beat
// uses dbp_pkg and one dbp_ram instance for both rings
`default_nettype none

module dbp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dbp_pkg::job_t head,
  input  wire logic          empty,
  output      logic          pop,
  output      dbp_pkg::rsp_t rsp,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall
);
  import dbp_pkg::*;

  logic       adv;
  logic       p1_valid;
  logic       p1_read;
  rsp_t       p1_rsp;
  rsp_t       p1_out;
  logic [7:0] ram_q;

  // result register free or being taken this cycle
  assign adv = !rsp_valid || !rsp_stall;
  assign pop = !empty && (!p1_valid || adv);

  dbp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (pop && head.do_write),
    .waddr (head.addr),
    .wdata (head.wdata),
    .re    (pop && head.do_read),
    .raddr (head.addr),
    .rdata (ram_q)
  );

  // merge the ram byte into the staged result
  always_comb begin
    p1_out           = p1_rsp;
    p1_out.read_data = p1_read ? ram_q : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        p1_valid <= 1'b1;
      end else if (adv) begin
        p1_valid <= 1'b0;
      end
      if (adv) begin
        rsp_valid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p1_read <= head.do_read;
      p1_rsp  <= head.rsp;
    end
    if (adv && p1_valid) begin
      rsp <= p1_out;
    end
  end

  a_read_has_room: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && !adv) |=> (p1_valid && $stable(p1_rsp)))
    else $error("in-flight read lost while result stalled");

endmodule

`default_nettype wire

### src/duplex_byte_pipe.sv
// duplex_byte_pipe: top level of the two-ended byte pipe
// ties dbp_front, dbp_queue and dbp_back together; uses dbp_pkg
//
// One operation beat in, one result beat out, in order. The block sustains one
// operation per clock when nothing stalls: the front part updates positions,
// counts and end state in the cycle it takes a beat, and the back part makes one
// access per job to the shared ring RAM (one write port, one registered read
// port); a result goes through the job queue, the p1 stage and the rsp register.
// A four-entry job queue lets operations keep coming while results are held
// back. Ring contents are not cleared by reset or open; only bytes written
// since the last open are ever read. Both rings are power-of-two sized.
`default_nettype none

module duplex_byte_pipe (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dbp_pkg::cmd_t cmd,
  input  wire logic          cmd_valid,
  output      logic          cmd_stall,
  output      dbp_pkg::rsp_t rsp,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall
);
  import dbp_pkg::*;

  job_t front_job;
  logic front_push;
  logic q_full;
  job_t q_head;
  logic q_empty;
  logic back_pop;

  dbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .job       (front_job),
    .job_push  (front_push),
    .job_full  (q_full)
  );

  dbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_job (front_job),
    .push     (front_push),
    .full     (q_full),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (back_pop)
  );

  dbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (back_pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

`default_nettype wire
